>>> rtl/sem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RGB Sobel edge magnitude block.
// Used by every module in rtl/; depends on nothing else.
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int ROW_W    = 14;
    localparam int PEND_W   = 22;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int SUM_W    = 21;
    localparam int ROOT_IN_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]  RESET_HEIGHT = 13'd480;
    localparam logic [SUM_W-1:0] SAT_LIMIT    = 21'd65280;
    localparam logic [CH_W-1:0]  SAT_VALUE    = 8'd255;

    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic {
        OP_PIXEL,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel;
    } item_t;

endpackage

>>> rtl/sem_front.sv
`timescale 1ns / 1ps
// Front end: takes input transfers, decodes the command and keeps a
// two-entry queue toward the back end. Depends on sem_pkg.
module sem_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [7:0]          pixel_red,
    input  logic [7:0]          pixel_green,
    input  logic [7:0]          pixel_blue,
    output logic                q_valid,
    input  logic                q_ready,
    output sem_pkg::item_t      q_item
);

    sem_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    sem_pkg::item_t new_item;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        new_item.op    = (command == sem_pkg::CMD_FLUSH) ? sem_pkg::OP_FLUSH
                                                         : sem_pkg::OP_PIXEL;
        new_item.pixel = {pixel_red, pixel_green, pixel_blue};
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> rtl/sem_root.sv
`timescale 1ns / 1ps
// Rounded integer square root, one result bit per cycle, saturating at 255.
// Depends on sem_pkg.
module sem_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sem_pkg::SUM_W-1:0]   value,
    output logic                        done,
    output logic [sem_pkg::CH_W-1:0]    root
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_ITER,
        R_FIX,
        R_DONE
    } rstate_t;

    rstate_t                          state_reg;
    logic [sem_pkg::CH_W-1:0]         root_reg;
    logic [sem_pkg::ROOT_IN_W-1:0]    us_reg;
    logic [2:0]                       bit_reg;
    logic [sem_pkg::CH_W-1:0]         trial;
    logic [2*sem_pkg::CH_W-1:0]       trial_sq;
    logic [2*sem_pkg::CH_W:0]         root_sq_plus;

    assign done = (state_reg == R_DONE);
    assign root = root_reg;

    always_comb
    begin
        trial        = root_reg | (sem_pkg::CH_W'(1) << bit_reg);
        trial_sq     = trial * trial;
        root_sq_plus = (2*sem_pkg::CH_W+1)'(root_reg * root_reg)
                     + (2*sem_pkg::CH_W+1)'(root_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            root_reg  <= '0;
            us_reg    <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        // A sum above the limit is clamped to it; its rounded root
                        // is 255, and every channel takes the same number of cycles.
                        if (value > sem_pkg::SAT_LIMIT)
                        begin
                            us_reg <= sem_pkg::ROOT_IN_W'(sem_pkg::SAT_LIMIT);
                        end
                        else
                        begin
                            us_reg <= value[sem_pkg::ROOT_IN_W-1:0];
                        end
                        bit_reg   <= 3'd7;
                        root_reg  <= '0;
                        state_reg <= R_ITER;
                    end
                end
                R_ITER:
                begin
                    if (trial_sq <= us_reg)
                    begin
                        root_reg <= trial;
                    end
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= R_FIX;
                    end
                    bit_reg <= bit_reg - 3'd1;
                end
                R_FIX:
                begin
                    // Round half up: s above r*r + r means the root is nearer r + 1.
                    if ((2*sem_pkg::CH_W+1)'(us_reg) > root_sq_plus)
                    begin
                        root_reg <= root_reg + 8'd1;
                    end
                    state_reg <= R_DONE;
                end
                R_DONE:
                begin
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/sem_back.sv
`timescale 1ns / 1ps
// Back end: frame position tracking, two row stores, 3x3 window, Sobel
// gradients, squares and three root units, plus the output register.
// Depends on sem_pkg and sem_root.
module sem_back #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  sem_pkg::item_t                  q_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      edge_red,
    output logic [7:0]                      edge_green,
    output logic [7:0]                      edge_blue,
    output logic                            frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = sem_pkg::ROW_W;
    localparam int HW = sem_pkg::FH_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_PUSH,
        S_GRAD,
        S_SQR,
        S_SUM,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_EMIT
    } state_t;

    state_t                         state_reg;
    logic [sem_pkg::FW_W-1:0]       frame_width_reg;
    logic [sem_pkg::FH_W-1:0]       frame_height_reg;
    logic [CW-1:0]                  col_reg;
    logic [RW-1:0]                  row_reg;
    logic [sem_pkg::PEND_W-1:0]     pend_reg;
    logic                           drain_reg;
    logic [1:0]                     tries_reg;
    logic [sem_pkg::PIX_W-1:0]      pix_reg;
    logic [sem_pkg::PIX_W-1:0]      upper_mem [MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0]      middle_mem [MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0]      upper_q_reg, middle_q_reg;
    logic [sem_pkg::PIX_W-1:0]      win_reg [3][3];
    logic [2:0]                     rmask_reg, cmask_reg;
    logic signed [sem_pkg::GRAD_W-1:0] gx_reg [3];
    logic signed [sem_pkg::GRAD_W-1:0] gy_reg [3];
    logic [sem_pkg::SQ_W-1:0]       gx2_reg [3];
    logic [sem_pkg::SQ_W-1:0]       gy2_reg [3];
    logic [sem_pkg::SUM_W-1:0]      sum_reg [3];
    logic                           out_valid_reg;
    logic [sem_pkg::CH_W-1:0]       edge_reg [3];
    logic                           frame_done_reg;

    logic [WW-1:0]                  w_eff;
    logic [HW-1:0]                  h_eff;
    logic                           col_wrap;
    logic [CW-1:0]                  col_adj;
    logic [RW-1:0]                  row_adj, row_wrap;
    logic                           draining;
    logic                           last_col;
    logic                           hit;
    logic [RW-1:0]                  qr;
    logic [WW-1:0]                  qc;
    logic [2:0]                     rmask, cmask;
    logic signed [sem_pkg::GRAD_W-1:0] gx [3];
    logic signed [sem_pkg::GRAD_W-1:0] gy [3];
    logic [2:0]                     root_done;
    logic [sem_pkg::CH_W-1:0]       root_val [3];
    logic                           root_start;
    logic                           emit_ok;
    logic [sem_pkg::PEND_W-1:0]     pend_dec;

    // Effective frame size: zero counts as one, oversize is clamped.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(frame_height_reg) > 32'(sem_pkg::MAX_HEIGHT))
        begin
            h_eff = HW'(sem_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    // Position fix-up before an item: wrap a stale column, restart a
    // finished frame when nothing is owed.
    always_comb
    begin
        col_wrap = (WW'(col_reg) >= w_eff);
        row_wrap = col_wrap ? row_reg + RW'(1) : row_reg;
        col_adj  = col_wrap ? '0 : col_reg;
        row_adj  = row_wrap;
        if ((row_wrap >= RW'(h_eff)) && (pend_reg == '0))
        begin
            col_adj = '0;
            row_adj = '0;
        end
        draining = (row_adj >= RW'(h_eff));
    end

    // Window geometry of the pixel one row and one column behind.
    always_comb
    begin
        last_col = ((WW'(col_reg) + WW'(1)) >= w_eff);
        hit      = !((row_reg == '0) || ((row_reg == RW'(1)) && (col_reg == '0)));
        if (col_reg == '0)
        begin
            qr = row_reg - RW'(2);
            qc = w_eff - WW'(1);
        end
        else
        begin
            qr = row_reg - RW'(1);
            qc = WW'(col_reg) - WW'(1);
        end
        rmask[0] = (qr != '0) && ((qr - RW'(1)) < RW'(h_eff));
        rmask[1] = (qr < RW'(h_eff));
        rmask[2] = ((RW+1)'(qr) + (RW+1)'(1)) < (RW+1)'(h_eff);
        cmask[0] = (qc != '0) && ((qc - WW'(1)) < w_eff);
        cmask[1] = (qc < w_eff);
        cmask[2] = ((WW+1)'(qc) + (WW+1)'(1)) < (WW+1)'(w_eff);
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [sem_pkg::CH_W-1:0] a [3][3];
            logic [9:0] px, nx, py, ny;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    a[k][j] = (rmask_reg[k] && cmask_reg[j])
                            ? win_reg[k][j][sem_pkg::PIX_W-1-sem_pkg::CH_W*ch -: sem_pkg::CH_W]
                            : '0;
                end
            end
            px = 10'(a[0][2]) + {1'b0, a[1][2], 1'b0} + 10'(a[2][2]);
            nx = 10'(a[0][0]) + {1'b0, a[1][0], 1'b0} + 10'(a[2][0]);
            py = 10'(a[2][0]) + {1'b0, a[2][1], 1'b0} + 10'(a[2][2]);
            ny = 10'(a[0][0]) + {1'b0, a[0][1], 1'b0} + 10'(a[0][2]);
            gx[ch] = $signed({1'b0, px}) - $signed({1'b0, nx});
            gy[ch] = $signed({1'b0, py}) - $signed({1'b0, ny});
        end
    end

    assign root_start = (state_reg == S_ROOT_GO);
    assign emit_ok    = !out_valid_reg || out_ready;
    assign pend_dec   = pend_reg - sem_pkg::PEND_W'(1);
    assign q_ready    = (state_reg == S_IDLE);

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_root
            sem_root u_root (
                .clk   (clk),
                .rst_n (rst_n),
                .start (root_start),
                .value (sum_reg[g]),
                .done  (root_done[g]),
                .root  (root_val[g])
            );
        end
    endgenerate

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= sem_pkg::RESET_WIDTH;
            frame_height_reg <= sem_pkg::RESET_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            drain_reg        <= 1'b0;
            tries_reg        <= '0;
            out_valid_reg    <= 1'b0;
            frame_done_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sem_pkg::REG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[sem_pkg::FW_W-1:0];
                    sem_pkg::REG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[sem_pkg::FH_W-1:0];
                    default: ;
                endcase
            end
            // The output register empties on a transfer unless a new result
            // is loaded at the same edge.
            if (out_valid_reg && out_ready && !((state_reg == S_EMIT) && emit_ok))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        col_reg   <= col_adj;
                        row_reg   <= row_adj;
                        tries_reg <= '0;
                        drain_reg <= draining;
                        if (draining)
                        begin
                            pix_reg   <= '0;
                            state_reg <= S_READ;
                        end
                        else if (q_item.op == sem_pkg::OP_PIXEL)
                        begin
                            pix_reg   <= q_item.pixel;
                            pend_reg  <= pend_reg + sem_pkg::PEND_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    win_reg[0][0] <= win_reg[0][1];
                    win_reg[1][0] <= win_reg[1][1];
                    win_reg[2][0] <= win_reg[2][1];
                    win_reg[0][1] <= win_reg[0][2];
                    win_reg[1][1] <= win_reg[1][2];
                    win_reg[2][1] <= win_reg[2][2];
                    win_reg[0][2] <= upper_q_reg;
                    win_reg[1][2] <= middle_q_reg;
                    win_reg[2][2] <= pix_reg;
                    rmask_reg     <= rmask;
                    cmask_reg     <= cmask;
                    if (last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        col_reg <= CW'(WW'(col_reg) + WW'(1));
                    end
                    priority if (hit)
                    begin
                        state_reg <= S_GRAD;
                    end
                    else if (drain_reg && (tries_reg != 2'd2))
                    begin
                        tries_reg <= tries_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_GRAD:
                begin
                    state_reg <= S_SQR;
                end
                S_SQR:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_ROOT_GO;
                end
                S_ROOT_GO:
                begin
                    state_reg <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT:
                begin
                    if (&root_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg  <= 1'b1;
                        pend_reg       <= pend_dec;
                        frame_done_reg <= drain_reg && (pend_dec == '0);
                        if (drain_reg && (pend_dec == '0))
                        begin
                            col_reg <= '0;
                            row_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers and row stores (no reset).
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            upper_q_reg  <= upper_mem[col_reg];
            middle_q_reg <= middle_mem[col_reg];
        end
        if (state_reg == S_PUSH)
        begin
            upper_mem[col_reg]  <= middle_q_reg;
            middle_mem[col_reg] <= pix_reg;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (state_reg == S_GRAD)
            begin
                gx_reg[ch] <= gx[ch];
                gy_reg[ch] <= gy[ch];
            end
            if (state_reg == S_SQR)
            begin
                gx2_reg[ch] <= sem_pkg::SQ_W'(gx_reg[ch] * gx_reg[ch]);
                gy2_reg[ch] <= sem_pkg::SQ_W'(gy_reg[ch] * gy_reg[ch]);
            end
            if (state_reg == S_SUM)
            begin
                sum_reg[ch] <= sem_pkg::SUM_W'(gx2_reg[ch]) + sem_pkg::SUM_W'(gy2_reg[ch]);
            end
            if ((state_reg == S_EMIT) && emit_ok)
            begin
                edge_reg[ch] <= root_val[ch];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_red   = edge_reg[0];
    assign edge_green = edge_reg[1];
    assign edge_blue  = edge_reg[2];
    assign frame_done = frame_done_reg;

endmodule

>>> rtl/sobel_edge_magnitude_rgb_core.sv
`timescale 1ns / 1ps
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_root and sem_back.

// RGB pixels enter in raster order; each result is the rounded Sobel gradient
// magnitude per channel (capped at 255) of the pixel one row and one column
// earlier, with neighbors outside the frame counted as zero. After the last
// pixel of a frame, send flush commands (command = 1) to drain the results
// still owed; the final one carries frame_done. A flush sent before the frame
// is complete, or while nothing is owed, produces nothing, and a pixel sent
// while draining is treated as a flush. A two-entry input queue keeps taking
// transfers while the back end works and while a result waits in the output
// register. The back end handles one item at a time: a pixel that produces a
// result passes through the row store read, window update, gradients,
// squares, then the bit-serial square root of 8 steps plus a rounding step;
// a pixel with no result passes only through the row store read and window
// update, and a drain flush may step the window up to three times. The row
// stores are MAX_WIDTH entries deep and need no clearing pass after reset.
// The user must write frame_width (index 0) and frame_height (index 1) only
// while the block is idle; the block itself does not enforce this.
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [7:0]                      pixel_red,
    input  logic [7:0]                      pixel_green,
    input  logic [7:0]                      pixel_blue,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      edge_red,
    output logic [7:0]                      edge_green,
    output logic [7:0]                      edge_blue,
    output logic                            frame_done
);

    logic           q_valid;
    logic           q_ready;
    sem_pkg::item_t q_item;

    // Front end: decodes each transfer and queues it.
    sem_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // Back end: line stores, window, arithmetic and the output register.
    sem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_red   (edge_red),
        .edge_green (edge_green),
        .edge_blue  (edge_blue),
        .frame_done (frame_done)
    );

endmodule
